// File: src/rss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants for the reset supervisor sequencer: request and
// action bit positions, register indexes, and the tick and result records.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int unsigned REQ_W   = 9;
	localparam int unsigned PEND_W  = 10;
	localparam int unsigned ACT_W   = 6;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	// request bits (new_requests / release_mask / pending set)
	localparam int unsigned REQ_RADIO  = 0;
	localparam int unsigned REQ_CPU    = 1;
	localparam int unsigned REQ_GATED_LO = 1;
	localparam int unsigned REQ_GATED_HI = 6;
	localparam int unsigned REQ_FPGA   = 6;
	localparam int unsigned REQ_3V3    = 7;
	localparam int unsigned REQ_VSYS   = 8;
	localparam int unsigned REQ_RADIO2 = 9;

	// action bits
	localparam int unsigned ACT_RADIO = 0;
	localparam int unsigned ACT_CPU   = 1;
	localparam int unsigned ACT_FPGA  = 2;
	localparam int unsigned ACT_3V3   = 3;
	localparam int unsigned ACT_VSYS  = 4;
	localparam int unsigned ACT_RESET = 5;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] DEF_MISSED_KICK_LIMIT = 8'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MONITOR_ENABLE    = 2'd0,
		CFG_MISSED_KICK_LIMIT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic             monitor_enable;
		logic [CNT_W-1:0] missed_kick_limit;
	} cfg_t;

	typedef struct packed {
		logic             radio_kick;
		logic             main_cpu_kick;
		logic             expander_busy;
		logic             link_up;
		logic [REQ_W-1:0] new_requests;
	} tick_t;

	typedef struct packed {
		logic [REQ_W-1:0] release_mask;
		logic             main_cpu_reset;
		logic             comms_reset;
		logic             expander_write;
		logic [ACT_W-1:0] action_bits;
		logic [CNT_W-1:0] missed_kicks;
	} result_t;

endpackage

`default_nettype wire

// File: src/rss_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_cfg
// Configuration register file: monitor enable and missed-kick limit.
// ----------------------------------------------------------------------------
module rss_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [rss_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [rss_pkg::CFG_DATA_W-1:0]      wr_data,
	output rss_pkg::cfg_t                            cfg
);

	logic                       monitor_enable_q;
	logic [rss_pkg::CNT_W-1:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_enable_q <= 1'b0;
			limit_q          <= rss_pkg::DEF_MISSED_KICK_LIMIT;
		end else if (wr_en) begin
			case (rss_pkg::cfg_reg_t'(wr_index))
				rss_pkg::CFG_MONITOR_ENABLE: begin
					monitor_enable_q <= wr_data[0];
				end
				rss_pkg::CFG_MISSED_KICK_LIMIT: begin
					limit_q <= wr_data[rss_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.monitor_enable    = monitor_enable_q;
	assign cfg.missed_kick_limit = limit_q;

endmodule

`default_nettype wire

// File: src/rss_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_eval
// Tick evaluation: pending request set and missed-kick counter, with the
// combinational service logic that produces one result per tick.
// ----------------------------------------------------------------------------
module rss_eval (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire rss_pkg::tick_t   tick,
	input  wire rss_pkg::cfg_t    cfg,
	output rss_pkg::result_t      res
);

	logic [rss_pkg::PEND_W-1:0] pend_q;
	logic [rss_pkg::CNT_W-1:0]  missed_q;

	logic [rss_pkg::PEND_W-1:0] pend_d;
	logic [rss_pkg::CNT_W-1:0]  missed_d;
	logic [rss_pkg::CNT_W-1:0]  inc;
	logic [rss_pkg::REQ_W-1:0]  rel;
	logic [rss_pkg::ACT_W-1:0]  act;
	logic [rss_pkg::REQ_GATED_HI:rss_pkg::REQ_GATED_LO] gated;
	logic                       wr;
	logic                       cpu_reset;

	always_comb begin
		pend_d    = pend_q | {1'b0, tick.new_requests};
		rel       = '0;
		act       = '0;
		wr        = 1'b0;
		cpu_reset = 1'b0;
		gated     = '0;

		if (pend_d[rss_pkg::REQ_RADIO2]) begin
			pend_d[rss_pkg::REQ_RADIO2] = 1'b0;
			rel[rss_pkg::REQ_RADIO]     = 1'b1;
			act[rss_pkg::ACT_RADIO]     = 1'b1;
			wr                          = 1'b1;
		end

		if (!tick.expander_busy) begin
			if (pend_d[rss_pkg::REQ_RADIO]) begin
				pend_d[rss_pkg::REQ_RADIO]  = 1'b0;
				pend_d[rss_pkg::REQ_RADIO2] = 1'b1;
			end
			gated = pend_d[rss_pkg::REQ_GATED_HI:rss_pkg::REQ_GATED_LO];
			rel[rss_pkg::REQ_GATED_HI:rss_pkg::REQ_GATED_LO] = gated;
			act[rss_pkg::ACT_CPU]  = pend_d[rss_pkg::REQ_CPU];
			act[rss_pkg::ACT_FPGA] = pend_d[rss_pkg::REQ_FPGA];
			pend_d[rss_pkg::REQ_GATED_HI:rss_pkg::REQ_GATED_LO] = '0;
			wr = wr | (|gated);
		end

		rel[rss_pkg::REQ_3V3]      = pend_d[rss_pkg::REQ_3V3];
		act[rss_pkg::ACT_3V3]      = pend_d[rss_pkg::REQ_3V3];
		pend_d[rss_pkg::REQ_3V3]   = 1'b0;
		rel[rss_pkg::REQ_VSYS]     = pend_d[rss_pkg::REQ_VSYS];
		act[rss_pkg::ACT_VSYS]     = pend_d[rss_pkg::REQ_VSYS];
		pend_d[rss_pkg::REQ_VSYS]  = 1'b0;

		inc = (missed_q == rss_pkg::CNT_MAX) ? missed_q : missed_q + 1'b1;
		if (tick.main_cpu_kick) begin
			missed_d = '0;
		end else if (cfg.monitor_enable && (inc >= cfg.missed_kick_limit)) begin
			missed_d                  = '0;
			cpu_reset                 = 1'b1;
			pend_d[rss_pkg::REQ_CPU]  = 1'b1;
			act[rss_pkg::ACT_RESET]   = 1'b1;
			wr                        = 1'b1;
		end else begin
			missed_d = inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			missed_q <= '0;
		end else if (step) begin
			pend_q   <= pend_d;
			missed_q <= missed_d;
		end
	end

	assign res.release_mask   = rel;
	assign res.main_cpu_reset = cpu_reset;
	assign res.comms_reset    = cpu_reset & tick.link_up;
	assign res.expander_write = wr;
	assign res.action_bits    = act;
	assign res.missed_kicks   = missed_d;

	// a kicked tick always clears the count
	a_kick_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && tick.main_cpu_kick |=> missed_q == '0)
		else $error("missed count not cleared by kick");

	// a cpu reset queues the cpu unreset
	a_reset_queues: assert property (@(posedge clk) disable iff (!arst_n)
		step && cpu_reset |=> pend_q[rss_pkg::REQ_CPU])
		else $error("cpu unreset not queued after reset");

	// rails never stay pending across a tick
	a_rails_served: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> !pend_q[rss_pkg::REQ_3V3] && !pend_q[rss_pkg::REQ_VSYS])
		else $error("rail request left pending");

endmodule

`default_nettype wire

// File: src/reset_supervisor_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reset_supervisor_sequencer
// Per-tick reset and power sequencing with main CPU kick supervision.
// ----------------------------------------------------------------------------
// Each request is one supervision tick and yields one result. A tick is
// registered on input, evaluated combinationally against the pending set and
// missed-kick counter, and the result is held in an output register, so one
// tick per cycle is accepted while out_ready does not stall the output. The
// pending-state update happens as a tick leaves the input register, so the
// next tick sees it without extra delay. Configuration is always ready.
module reset_supervisor_sequencer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [rss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rss_pkg::CFG_DATA_W-1:0]    cfg_data,

	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic                              radio_kick,
	input  wire logic                              main_cpu_kick,
	input  wire logic                              expander_busy,
	input  wire logic                              link_up,
	input  wire logic [rss_pkg::REQ_W-1:0]         new_requests,

	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [rss_pkg::REQ_W-1:0]         release_mask,
	output      logic                              main_cpu_reset,
	output      logic                              comms_reset,
	output      logic                              expander_write,
	output      logic [rss_pkg::ACT_W-1:0]         action_bits,
	output      logic [rss_pkg::CNT_W-1:0]         missed_kicks
);

	rss_pkg::cfg_t    cfg;
	rss_pkg::tick_t   tick_s1;
	logic             valid_s1;
	rss_pkg::result_t res;
	rss_pkg::result_t res_s2;
	logic             valid_s2;
	logic             advance;

	assign cfg_ready = 1'b1;

	rss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.radio_kick    <= radio_kick;
			tick_s1.main_cpu_kick <= main_cpu_kick;
			tick_s1.expander_busy <= expander_busy;
			tick_s1.link_up       <= link_up;
			tick_s1.new_requests  <= new_requests;
		end
	end

	rss_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (tick_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign release_mask   = res_s2.release_mask;
	assign main_cpu_reset = res_s2.main_cpu_reset;
	assign comms_reset    = res_s2.comms_reset;
	assign expander_write = res_s2.expander_write;
	assign action_bits    = res_s2.action_bits;
	assign missed_kicks   = res_s2.missed_kicks;

	a_comms_needs_reset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && comms_reset |-> main_cpu_reset)
		else $error("comms reset without cpu reset");

	a_reset_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && main_cpu_reset |->
			missed_kicks == '0 && action_bits[rss_pkg::ACT_RESET] && expander_write)
		else $error("inconsistent cpu reset result");

	a_radio_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && release_mask[rss_pkg::REQ_RADIO] |->
			action_bits[rss_pkg::ACT_RADIO] && expander_write)
		else $error("radio release without action or expander write");

endmodule

`default_nettype wire
